/* rtl/mtep_pkg.sv */
// package for the track event parser: payload types, codes, command length table
// no dependencies

package mtep_pkg;

  localparam int MAX_PARAM_BYTES_DEF = 3;
  localparam int NUM_CFG_REGS = 8;
  localparam int CFG_IDX_W = 4;
  localparam int QDEPTH = 4;
  localparam int QPW = $clog2(QDEPTH);

  localparam int REG_NOTE_START = 0;
  localparam int REG_NOTE_END = 1;
  localparam int REG_TIE_CODE = 2;
  localparam int REG_REST_START = 3;
  localparam int REG_REST_END = 4;
  localparam int REG_PERC_START = 5;
  localparam int REG_PERC_END = 6;
  localparam int REG_VCMD_START = 7;

  localparam logic [7:0] CFG_RESET [NUM_CFG_REGS] = '{
    8'd128, 8'd199, 8'd200, 8'd201, 8'd201, 8'd202, 8'd223, 8'd224
  };

  localparam logic [7:0] BYTE_END = 8'h00;
  localparam logic [7:0] DUR_MAX = 8'h7F;
  localparam logic [7:0] CMD_FIRST = 8'hE0;
  localparam logic [7:0] CMD_UNUSED = 8'hFF;

  localparam logic [1:0] CMD_LEN [32] = '{
    2'd1, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd1,
    2'd2, 2'd1, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
    2'd1, 2'd3, 2'd3, 2'd0, 2'd1, 2'd3, 2'd0, 2'd3,
    2'd3, 2'd3, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0
  };

  typedef enum logic [1:0] {
    PH_DONE,
    PH_IDLE,
    PH_DUR,
    PH_PARAM
  } phase_t;

  typedef enum logic [3:0] {
    K_END  = 4'd0,
    K_DUR  = 4'd1,
    K_NOTE = 4'd2,
    K_TIE  = 4'd3,
    K_REST = 4'd4,
    K_PERC = 4'd5,
    K_CMD  = 4'd6,
    K_STOP = 4'd7,
    K_ERR  = 4'd8
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           wdata;
  } cfg_t;

  typedef struct packed {
    kind_t       event_kind;
    logic [7:0]  value;
    logic [7:0]  param_a;
    logic [7:0]  param_b;
    logic [7:0]  param_c;
    logic        has_modifier;
    logic [2:0]  quantization;
    logic [3:0]  velocity;
    logic [15:0] event_offset;
  } res_t;

  typedef struct packed {
    kind_t       event_kind;
    logic [7:0]  value;
    logic [7:0]  param_a;
    logic [7:0]  param_b;
    logic [7:0]  param_c;
    logic        has_modifier;
    logic [2:0]  quantization;
    logic [3:0]  velocity;
    logic [15:0] event_offset;
    logic        last_of_run;
  } out_t;

  // one queue entry holds all results of one byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [1:0] cmd_len(input logic [7:0] code);
    if (code < CMD_FIRST) begin
      return 2'd0;
    end
    return CMD_LEN[code[4:0]];
  endfunction

  function automatic res_t mk_res(input kind_t kind, input logic [7:0] value,
                                  input logic [15:0] off);
    res_t r;
    r = '0;
    r.event_kind = kind;
    r.value = value;
    r.event_offset = off;
    return r;
  endfunction

endpackage

/* rtl/mtep_chan_if.sv */
// valid/ready channel carrying one payload item of type T
// uses the payload types of mtep_pkg through its type parameter

interface mtep_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/mtep_front.sv */
// front part: config registers, byte classification and parse state
// depends on mtep_pkg and mtep_chan_if; pushes the results of each byte into the queue

module mtep_front #(
  parameter int MAX_PARAM_BYTES = mtep_pkg::MAX_PARAM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  mtep_chan_if.sink          in_if,
  mtep_chan_if.sink          cfg_if,
  input  mtep_pkg::q_stat_t  q_stat,
  output logic               push,
  output mtep_pkg::q_entry_t push_entry
);
  import mtep_pkg::*;

  localparam int IW = (MAX_PARAM_BYTES > 1) ? $clog2(MAX_PARAM_BYTES) : 1;

  logic [7:0]  cfg_r [NUM_CFG_REGS];
  phase_t      phase_r, phase_nxt, eff_phase;
  logic [6:0]  pending_r, pending_nxt;
  logic [7:0]  cmd_id_r, cmd_id_nxt;
  logic [7:0]  params_r [MAX_PARAM_BYTES];
  logic [7:0]  params_nxt [MAX_PARAM_BYTES];
  logic [7:0]  eff_params [MAX_PARAM_BYTES];
  logic [1:0]  left_r, left_nxt, left_dec;
  logic [15:0] evt_start_r, evt_start_nxt;
  logic [15:0] byte_pos_r, byte_pos_nxt;

  logic [7:0]  b;
  logic        last, accept;
  logic [15:0] pos, next_pos;
  logic [1:0]  idx, b_len;

  logic [1:0]  se_cnt;
  res_t        se_r0, se_r1;
  phase_t      se_phase;
  logic        se_hold_dur, se_hold_cmd, se_clr, se_fin;

  logic [1:0]  n;
  res_t        r0, r1;

  assign b = in_if.data.data_byte;
  assign last = in_if.data.last_byte;
  assign in_if.ready = !q_stat.full;
  assign cfg_if.ready = 1'b1;
  assign accept = in_if.valid && in_if.ready;

  assign eff_phase = in_if.data.first_byte ? PH_IDLE : phase_r;
  assign pos = in_if.data.first_byte ? 16'd0 : byte_pos_r;
  assign next_pos = pos + 16'd1;
  assign b_len = cmd_len(b);

  always_comb begin
    for (int i = 0; i < MAX_PARAM_BYTES; i++) begin
      eff_params[i] = in_if.data.first_byte ? 8'd0 : params_r[i];
    end
  end

  // classification of a byte that opens a new event
  always_comb begin
    se_cnt = 2'd0;
    se_r0 = mk_res(K_END, 8'd0, pos);
    se_r1 = mk_res(K_STOP, 8'd0, next_pos);
    se_phase = PH_IDLE;
    se_hold_dur = 1'b0;
    se_hold_cmd = 1'b0;
    se_clr = 1'b0;
    se_fin = 1'b0;
    priority if (b == BYTE_END) begin
      se_cnt = 2'd1;
      se_phase = PH_DONE;
    end else if (b <= DUR_MAX) begin
      if (last) begin
        se_r0 = mk_res(K_DUR, b, pos);
        se_cnt = 2'd2;
        se_phase = PH_DONE;
      end else begin
        se_hold_dur = 1'b1;
        se_phase = PH_DUR;
      end
    end else if (b >= cfg_r[REG_NOTE_START] && b <= cfg_r[REG_NOTE_END]) begin
      se_r0 = mk_res(K_NOTE, b - cfg_r[REG_NOTE_START], pos);
      se_cnt = 2'd1;
      se_fin = 1'b1;
    end else if (b == cfg_r[REG_TIE_CODE]) begin
      se_r0 = mk_res(K_TIE, 8'd0, pos);
      se_cnt = 2'd1;
      se_fin = 1'b1;
    end else if (b >= cfg_r[REG_REST_START] && b <= cfg_r[REG_REST_END]) begin
      se_r0 = mk_res(K_REST, 8'd0, pos);
      se_cnt = 2'd1;
      se_fin = 1'b1;
    end else if (b >= cfg_r[REG_PERC_START] && b <= cfg_r[REG_PERC_END]) begin
      se_r0 = mk_res(K_PERC, b - cfg_r[REG_PERC_START], pos);
      se_cnt = 2'd1;
      se_fin = 1'b1;
    end else if (b >= cfg_r[REG_VCMD_START]) begin
      if (b == CMD_UNUSED || b < CMD_FIRST) begin
        se_r0 = mk_res(K_ERR, b, pos);
        se_cnt = 2'd1;
        se_phase = PH_DONE;
      end else begin
        se_clr = 1'b1;
        if (b_len == 2'd0) begin
          se_r0 = mk_res(K_CMD, b, pos);
          se_cnt = 2'd1;
          se_fin = 1'b1;
        end else if (last) begin
          se_r0 = mk_res(K_STOP, 8'd0, pos);
          se_cnt = 2'd1;
          se_phase = PH_DONE;
        end else begin
          se_hold_cmd = 1'b1;
          se_phase = PH_PARAM;
        end
      end
    end else begin
      se_fin = 1'b1;
    end
    if (se_fin && last) begin
      se_phase = PH_DONE;
      if (se_cnt == 2'd0) begin
        se_r0 = mk_res(K_STOP, 8'd0, next_pos);
        se_cnt = 2'd1;
      end else begin
        se_cnt = 2'd2;
      end
    end
  end

  // parse state update and results of the current byte
  always_comb begin
    phase_nxt = eff_phase;
    pending_nxt = in_if.data.first_byte ? 7'd0 : pending_r;
    cmd_id_nxt = cmd_id_r;
    left_nxt = in_if.data.first_byte ? 2'd0 : left_r;
    evt_start_nxt = evt_start_r;
    byte_pos_nxt = pos;
    params_nxt = eff_params;
    idx = cmd_len(cmd_id_r) - left_r;
    left_dec = (left_r != 2'd0) ? left_r - 2'd1 : 2'd0;
    n = 2'd0;
    r0 = se_r0;
    r1 = se_r1;
    if (eff_phase != PH_DONE) begin
      byte_pos_nxt = next_pos;
      unique case (eff_phase)
        PH_DUR: begin
          phase_nxt = PH_IDLE;
          if (b != BYTE_END && b <= DUR_MAX) begin
            r0 = mk_res(K_DUR, {1'b0, pending_r}, evt_start_r);
            r0.has_modifier = 1'b1;
            r0.quantization = b[6:4];
            r0.velocity = b[3:0];
            n = 2'd1;
            if (last) begin
              phase_nxt = PH_DONE;
              r1 = mk_res(K_STOP, 8'd0, next_pos);
              n = 2'd2;
            end
          end else begin
            r0 = mk_res(K_DUR, {1'b0, pending_r}, evt_start_r);
            r1 = se_r0;
            n = (se_cnt != 2'd0) ? 2'd2 : 2'd1;
            phase_nxt = se_phase;
            if (se_hold_dur) begin
              pending_nxt = b[6:0];
              evt_start_nxt = pos;
            end
            if (se_hold_cmd) begin
              cmd_id_nxt = b;
              left_nxt = b_len;
              evt_start_nxt = pos;
            end
            if (se_clr) begin
              for (int i = 0; i < MAX_PARAM_BYTES; i++) params_nxt[i] = 8'd0;
            end
          end
        end
        PH_PARAM: begin
          if (int'(idx) < MAX_PARAM_BYTES) begin
            params_nxt[IW'(idx)] = b;
          end
          left_nxt = left_dec;
          if (left_dec == 2'd0) begin
            phase_nxt = PH_IDLE;
            r0 = mk_res(K_CMD, cmd_id_r, evt_start_r);
            r0.param_a = params_nxt[0];
            r0.param_b = params_nxt[1];
            r0.param_c = params_nxt[2];
            n = 2'd1;
            if (last) begin
              phase_nxt = PH_DONE;
              r1 = mk_res(K_STOP, 8'd0, next_pos);
              n = 2'd2;
            end
          end else if (last) begin
            phase_nxt = PH_DONE;
            left_nxt = 2'd0;
            r0 = mk_res(K_STOP, 8'd0, evt_start_r);
            n = 2'd1;
          end
        end
        PH_IDLE: begin
          n = se_cnt;
          phase_nxt = se_phase;
          if (se_hold_dur) begin
            pending_nxt = b[6:0];
            evt_start_nxt = pos;
          end
          if (se_hold_cmd) begin
            cmd_id_nxt = b;
            left_nxt = b_len;
            evt_start_nxt = pos;
          end
          if (se_clr) begin
            for (int i = 0; i < MAX_PARAM_BYTES; i++) params_nxt[i] = 8'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push = accept && (n != 2'd0);
  assign push_entry.two = (n == 2'd2);
  assign push_entry.r0 = r0;
  assign push_entry.r1 = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG_REGS; i++) cfg_r[i] <= CFG_RESET[i];
    end else if (cfg_if.valid && cfg_if.ready &&
                 int'(cfg_if.data.index) < NUM_CFG_REGS) begin
      cfg_r[cfg_if.data.index[$clog2(NUM_CFG_REGS)-1:0]] <= cfg_if.data.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      pending_r <= '0;
      cmd_id_r <= '0;
      left_r <= '0;
      evt_start_r <= '0;
      byte_pos_r <= '0;
      for (int i = 0; i < MAX_PARAM_BYTES; i++) params_r[i] <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pending_r <= pending_nxt;
      cmd_id_r <= cmd_id_nxt;
      left_r <= left_nxt;
      evt_start_r <= evt_start_nxt;
      byte_pos_r <= byte_pos_nxt;
      for (int i = 0; i < MAX_PARAM_BYTES; i++) params_r[i] <= params_nxt[i];
    end
  end

endmodule

/* rtl/mtep_queue.sv */
// short result queue between parser front and output back
// depends on mtep_pkg; one entry per byte that gave results

module mtep_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mtep_pkg::q_entry_t push_entry,
  input  logic               pop,
  output mtep_pkg::q_entry_t head,
  output mtep_pkg::q_stat_t  q_stat
);
  import mtep_pkg::*;

  q_entry_t       mem [QDEPTH];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPW:0]   count_r, count_nxt;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full = (count_r == (QPW+1)'(QDEPTH));
  assign head = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/mtep_back.sv */
// back part: hands out the one or two results of each queue entry in order
// depends on mtep_pkg and mtep_chan_if

module mtep_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mtep_pkg::q_entry_t head,
  input  mtep_pkg::q_stat_t  q_stat,
  output logic               pop,
  mtep_chan_if.source        out_if
);
  import mtep_pkg::*;

  logic sub_r, sub_nxt;
  logic last_sel;
  res_t sel;

  assign sel = sub_r ? head.r1 : head.r0;
  assign last_sel = sub_r || !head.two;

  assign out_if.valid = !q_stat.empty;
  assign out_if.data.event_kind = sel.event_kind;
  assign out_if.data.value = sel.value;
  assign out_if.data.param_a = sel.param_a;
  assign out_if.data.param_b = sel.param_b;
  assign out_if.data.param_c = sel.param_c;
  assign out_if.data.has_modifier = sel.has_modifier;
  assign out_if.data.quantization = sel.quantization;
  assign out_if.data.velocity = sel.velocity;
  assign out_if.data.event_offset = sel.event_offset;
  assign out_if.data.last_of_run = last_sel;

  assign pop = out_if.valid && out_if.ready && last_sel;

  always_comb begin
    sub_nxt = sub_r;
    if (out_if.valid && out_if.ready) begin
      sub_nxt = !last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

/* rtl/music_track_event_parser_core.sv */
// top level of the track event parser: front, result queue and back
// depends on mtep_pkg, mtep_chan_if, mtep_front, mtep_queue, mtep_back
//
// channel  dir  payload                                   item
// in_if    in   data_byte, first_byte, last_byte          one track byte
// cfg_if   in   index, wdata                              one register write
// out_if   out  event_kind .. event_offset, last_of_run   one parsed result
//
// one byte taken per cycle unless the queue is full; state updates in that cycle
// a byte gives zero, one or two results; the back hands one out per ready cycle
// a four-entry queue of per-byte results lets input and output stall apart
// reset is synchronous: parser waits for a first byte, registers take defaults

module music_track_event_parser_core #(
  parameter int MAX_PARAM_BYTES = mtep_pkg::MAX_PARAM_BYTES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mtep_chan_if.sink   in_if,
  mtep_chan_if.sink   cfg_if,
  mtep_chan_if.source out_if
);
  import mtep_pkg::*;

  logic     push, pop;
  q_entry_t push_entry, head;
  q_stat_t  q_stat;

  mtep_front #(
    .MAX_PARAM_BYTES(MAX_PARAM_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .cfg_if     (cfg_if),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  mtep_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  mtep_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_if (out_if)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("push into full queue");

  a_empty_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !out_if.valid)
    else $error("result shown from empty queue");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !q_stat.empty)
    else $error("pushed item lost");

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_if.ready)
    else $error("input taken while queue full");

endmodule

/* bench/track_event_checker.sv */
`timescale 1ns / 100ps
// result checker for music_track_event_parser_core: tracks register writes,
// predicts the results of every accepted track byte and compares the out channel
// depends on mtep_pkg

module track_event_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  mtep_pkg::in_t  in_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  mtep_pkg::cfg_t cfg_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  mtep_pkg::out_t out_data,
  output int             fail_count,
  output int             open_results
);
  import mtep_pkg::*;

  localparam int PARAM_SLOTS = 3;
  localparam logic [7:0] DUR_MIN = 8'h01;

  localparam logic [1:0] PARAM_COUNT [32] = '{
    2'd1, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd1,
    2'd2, 2'd1, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
    2'd1, 2'd3, 2'd3, 2'd0, 2'd1, 2'd3, 2'd0, 2'd3,
    2'd3, 2'd3, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 2'd0
  };

  logic [7:0]  code_reg [NUM_CFG_REGS];
  phase_t      parse_phase;
  logic [6:0]  held_ticks;
  logic [7:0]  held_cmd;
  logic [7:0]  held_params [PARAM_SLOTS];
  logic [1:0]  params_due;
  logic [15:0] held_start;
  logic [15:0] byte_pos;

  out_t        byte_events [2];
  int          byte_count;
  out_t        expected_events [$];

  initial begin
    fail_count = 0;
    open_results = 0;
  end

  function automatic logic [1:0] param_count(input logic [7:0] code);
    if (code < CMD_FIRST) return 2'd0;
    return PARAM_COUNT[code - CMD_FIRST];
  endfunction

  function automatic void clear_params();
    for (int i = 0; i < PARAM_SLOTS; i++) held_params[i] = 8'h00;
  endfunction

  function automatic void add_event(input kind_t kind, input logic [7:0] value,
                                    input logic mod, input logic [7:0] mod_byte,
                                    input logic [15:0] offset, input logic with_params);
    out_t e;
    if (byte_count >= 2) return;
    e = '0;
    e.event_kind = kind;
    e.value = value;
    if (with_params) begin
      e.param_a = held_params[0];
      e.param_b = held_params[1];
      e.param_c = held_params[2];
    end
    e.has_modifier = mod;
    if (mod) begin
      e.quantization = mod_byte[6:4];
      e.velocity = mod_byte[3:0];
    end
    e.event_offset = offset;
    byte_events[byte_count] = e;
    byte_count++;
  endfunction

  // stop after a completed event on the last byte, if there is room
  function automatic void close_on_last(input logic last, input logic [15:0] next);
    if (!last) return;
    parse_phase = PH_DONE;
    add_event(K_STOP, 8'h00, 1'b0, 8'h00, next, 1'b0);
  endfunction

  function automatic void begin_event(input logic [7:0] b, input logic [15:0] pos,
                                      input logic last, input logic [15:0] next);
    logic [1:0] cnt;
    if (b == BYTE_END) begin
      parse_phase = PH_DONE;
      add_event(K_END, 8'h00, 1'b0, 8'h00, pos, 1'b0);
      return;
    end
    if (b <= DUR_MAX) begin
      if (last) begin
        add_event(K_DUR, b, 1'b0, 8'h00, pos, 1'b0);
        close_on_last(1'b1, next);
      end else begin
        held_ticks = b[6:0];
        held_start = pos;
        parse_phase = PH_DUR;
      end
      return;
    end
    if (b >= code_reg[REG_NOTE_START] && b <= code_reg[REG_NOTE_END]) begin
      add_event(K_NOTE, b - code_reg[REG_NOTE_START], 1'b0, 8'h00, pos, 1'b0);
    end else if (b == code_reg[REG_TIE_CODE]) begin
      add_event(K_TIE, 8'h00, 1'b0, 8'h00, pos, 1'b0);
    end else if (b >= code_reg[REG_REST_START] && b <= code_reg[REG_REST_END]) begin
      add_event(K_REST, 8'h00, 1'b0, 8'h00, pos, 1'b0);
    end else if (b >= code_reg[REG_PERC_START] && b <= code_reg[REG_PERC_END]) begin
      add_event(K_PERC, b - code_reg[REG_PERC_START], 1'b0, 8'h00, pos, 1'b0);
    end else if (b >= code_reg[REG_VCMD_START]) begin
      if (b == CMD_UNUSED || b < CMD_FIRST) begin
        parse_phase = PH_DONE;
        add_event(K_ERR, b, 1'b0, 8'h00, pos, 1'b0);
        return;
      end
      cnt = param_count(b);
      clear_params();
      if (cnt == 2'd0) begin
        add_event(K_CMD, b, 1'b0, 8'h00, pos, 1'b1);
      end else if (last) begin
        parse_phase = PH_DONE;
        add_event(K_STOP, 8'h00, 1'b0, 8'h00, pos, 1'b0);
        return;
      end else begin
        held_cmd = b;
        params_due = cnt;
        held_start = pos;
        parse_phase = PH_PARAM;
        return;
      end
    end
    close_on_last(last, next);
  endfunction

  function automatic void clear_parser();
    code_reg = CFG_RESET;
    parse_phase = PH_DONE;
    held_ticks = '0;
    held_cmd = '0;
    clear_params();
    params_due = '0;
    held_start = '0;
    byte_pos = '0;
  endfunction

  task automatic parse_track_byte(input in_t item);
    logic [7:0]  b;
    logic [15:0] pos;
    logic [15:0] next;
    int          slot;
    b = item.data_byte;
    byte_count = 0;
    if (item.first_byte) begin
      parse_phase = PH_IDLE;
      byte_pos = '0;
      held_ticks = '0;
      params_due = '0;
      clear_params();
    end
    if (parse_phase == PH_DONE) return;
    pos = byte_pos;
    next = pos + 16'd1;
    byte_pos = next;
    case (parse_phase)
      PH_DUR: begin
        parse_phase = PH_IDLE;
        if (b >= DUR_MIN && b <= DUR_MAX) begin
          add_event(K_DUR, {1'b0, held_ticks}, 1'b1, b, held_start, 1'b0);
          close_on_last(item.last_byte, next);
        end else begin
          add_event(K_DUR, {1'b0, held_ticks}, 1'b0, 8'h00, held_start, 1'b0);
          begin_event(b, pos, item.last_byte, next);
        end
      end
      PH_PARAM: begin
        slot = int'(param_count(held_cmd)) - int'(params_due);
        if (slot >= 0 && slot < PARAM_SLOTS) held_params[slot[1:0]] = b;
        if (params_due > 2'd0) params_due--;
        if (params_due == 2'd0) begin
          parse_phase = PH_IDLE;
          add_event(K_CMD, held_cmd, 1'b0, 8'h00, held_start, 1'b1);
          close_on_last(item.last_byte, next);
        end else if (item.last_byte) begin
          parse_phase = PH_DONE;
          params_due = '0;
          add_event(K_STOP, 8'h00, 1'b0, 8'h00, held_start, 1'b0);
        end
      end
      default: begin_event(b, pos, item.last_byte, next);
    endcase
    if (byte_count > 0) begin
      byte_events[byte_count - 1].last_of_run = 1'b1;
      for (int i = 0; i < byte_count; i++) expected_events = {expected_events, byte_events[i]};
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want, input logic [15:0] off);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h, event at offset %0d",
                                name, got, want, off));
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d offset %0d",
                                got.event_kind, got.event_offset));
      return;
    end
    want = expected_events.pop_front();
    compare_field("event_kind", 16'(got.event_kind), 16'(want.event_kind),
                  want.event_offset);
    compare_field("value", 16'(got.value), 16'(want.value), want.event_offset);
    compare_field("param_a", 16'(got.param_a), 16'(want.param_a), want.event_offset);
    compare_field("param_b", 16'(got.param_b), 16'(want.param_b), want.event_offset);
    compare_field("param_c", 16'(got.param_c), 16'(want.param_c), want.event_offset);
    compare_field("has_modifier", 16'(got.has_modifier), 16'(want.has_modifier),
                  want.event_offset);
    compare_field("quantization", 16'(got.quantization), 16'(want.quantization),
                  want.event_offset);
    compare_field("velocity", 16'(got.velocity), 16'(want.velocity), want.event_offset);
    compare_field("event_offset", got.event_offset, want.event_offset, want.event_offset);
    compare_field("last_of_run", 16'(got.last_of_run), 16'(want.last_of_run),
                  want.event_offset);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      expected_events.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_data.index < NUM_CFG_REGS) begin
        code_reg[cfg_data.index[$clog2(NUM_CFG_REGS)-1:0]] = cfg_data.wdata;
      end
      if (in_valid && in_ready) parse_track_byte(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    open_results = expected_events.size();
  end

endmodule

/* bench/music_track_event_parser_core_tb.sv */
`timescale 1ns / 100ps
// testbench top for music_track_event_parser_core: sends track bytes with random stalls and
// register writes, track_event_checker predicts and compares results
// depends on mtep_pkg, mtep_chan_if, track_event_checker, music_track_event_parser_core

module music_track_event_parser_core_tb;
  import mtep_pkg::*;

  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 135;
  localparam int IDLE_PCT = 22;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       calm = 1'b0;
  int         fail_count;
  int         open_results;
  int         sent_count = 0;
  int         target;
  logic [7:0] code_set [NUM_CFG_REGS];

  mtep_chan_if #(.T(in_t))  in_if ();
  mtep_chan_if #(.T(cfg_t)) cfg_if ();
  mtep_chan_if #(.T(out_t)) out_if ();

  music_track_event_parser_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .cfg_if(cfg_if),
    .out_if(out_if)
  );

  track_event_checker u_chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_if.valid),
    .in_ready(in_if.ready),
    .in_data(in_if.data),
    .cfg_valid(cfg_if.valid),
    .cfg_ready(cfg_if.ready),
    .cfg_data(cfg_if.data),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .out_data(out_if.data),
    .fail_count(fail_count),
    .open_results(open_results)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    #5_000_000;
    $display("FAIL music_track_event_parser_core");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    in_t item;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    item.data_byte = b;
    item.first_byte = first;
    item.last_byte = last;
    in_if.valid <= 1'b1;
    in_if.data <= item;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
    sent_count++;
  endtask

  task automatic write_reg(input int idx, input logic [7:0] v);
    cfg_t w;
    w.index = idx[CFG_IDX_W-1:0];
    w.wdata = v;
    cfg_if.valid <= 1'b1;
    cfg_if.data <= w;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    if (idx < NUM_CFG_REGS) code_set[idx] = v;
  endtask

  task automatic write_codes(input logic [7:0] ns, input logic [7:0] ne,
                             input logic [7:0] tie, input logic [7:0] rs,
                             input logic [7:0] re, input logic [7:0] ps,
                             input logic [7:0] pe, input logic [7:0] vs);
    logic [7:0] v [NUM_CFG_REGS];
    int         start;
    v[REG_NOTE_START] = ns;
    v[REG_NOTE_END] = ne;
    v[REG_TIE_CODE] = tie;
    v[REG_REST_START] = rs;
    v[REG_REST_END] = re;
    v[REG_PERC_START] = ps;
    v[REG_PERC_END] = pe;
    v[REG_VCMD_START] = vs;
    start = $urandom_range(NUM_CFG_REGS - 1);
    for (int k = 0; k < NUM_CFG_REGS; k++) begin
      write_reg((start + k) % NUM_CFG_REGS, v[(start + k) % NUM_CFG_REGS]);
    end
    // unmapped index, must change nothing
    if ($urandom_range(1) == 1) begin
      write_reg(NUM_CFG_REGS + $urandom_range(7), 8'($urandom_range(255)));
    end
    cfg_if.valid <= 1'b0;
  endtask

  // wait until the parser has drained before touching registers
  task automatic settle();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (open_results != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic bit takes_params(input logic [7:0] b);
    if (b <= DUR_MAX) return 1'b0;
    if (b >= code_set[REG_NOTE_START] && b <= code_set[REG_NOTE_END]) return 1'b0;
    if (b == code_set[REG_TIE_CODE]) return 1'b0;
    if (b >= code_set[REG_REST_START] && b <= code_set[REG_REST_END]) return 1'b0;
    if (b >= code_set[REG_PERC_START] && b <= code_set[REG_PERC_END]) return 1'b0;
    if (b < code_set[REG_VCMD_START] || b == CMD_UNUSED || b < CMD_FIRST) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_track();
    logic [7:0] track [$];
    logic [7:0] b;
    int         n_events;
    int         r;
    int         stop_at;
    n_events = $urandom_range(1, 12);
    for (int i = 0; i < n_events; i++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        track = {track, 8'($urandom_range(1, 127))};
        if ($urandom_range(1) == 1) track = {track, 8'($urandom_range(1, 127))};
      end else if (r < 88) begin
        b = (r < 80) ? 8'($urandom_range(128, 254)) : 8'($urandom_range(224, 254));
        track = {track, b};
        if (takes_params(b)) begin
          repeat (cmd_len(b)) track = {track, 8'($urandom_range(255))};
        end
      end else if (r < 92) begin
        track = {track, BYTE_END};
        break;
      end else if (r < 95) begin
        track = {track, CMD_UNUSED};
        break;
      end else begin
        track = {track, 8'($urandom_range(255))};
      end
    end
    r = $urandom_range(99);
    if (r < 45) stop_at = track.size() - 1;
    else if (r < 60) stop_at = $urandom_range(track.size() - 1);
    else stop_at = -1;
    foreach (track[i]) send_byte(track[i], i == 0, i == stop_at);
  endtask

  task automatic send_noise();
    int len;
    len = $urandom_range(1, 8);
    repeat (len) begin
      send_byte(8'($urandom_range(255)), $urandom_range(3) == 0, $urandom_range(7) == 0);
    end
  endtask

  initial begin
    int a0;
    int a1;
    int a2;
    int a3;
    int a4;
    int a5;
    int a6;
    int a7;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    foreach (code_set[i]) code_set[i] = CFG_RESET[i];
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, default codes
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h05, 1'b1, 1'b0);
    send_byte(8'h35, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'hC7, 1'b0, 1'b0);
    send_byte(8'hC8, 1'b0, 1'b0);
    send_byte(8'hC9, 1'b0, 1'b0);
    send_byte(8'hCA, 1'b0, 1'b0);
    send_byte(8'hDF, 1'b0, 1'b0);
    send_byte(8'hE4, 1'b0, 1'b0);
    send_byte(8'hE3, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'hE0, 1'b0, 1'b0);
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(BYTE_END, 1'b0, 1'b0);
    send_byte(8'h44, 1'b0, 1'b0);
    send_byte(CMD_UNUSED, 1'b1, 1'b0);
    send_byte(8'h01, 1'b1, 1'b1);
    send_byte(8'hE3, 1'b1, 1'b0);
    send_byte(8'h11, 1'b0, 1'b0);
    send_byte(8'h22, 1'b0, 1'b1);
    send_byte(8'h10, 1'b1, 1'b0);
    send_byte(8'h90, 1'b0, 1'b1);
    send_byte(8'hE4, 1'b1, 1'b1);
    send_byte(8'hE0, 1'b1, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        1: begin
          a0 = 128 + $urandom_range(20);
          a1 = a0 + $urandom_range(40);
          a2 = a1 + $urandom_range(1, 3);
          a3 = a2 + $urandom_range(2);
          a4 = a3 + $urandom_range(4);
          a5 = a4 + $urandom_range(1, 3);
          a6 = a5 + $urandom_range(20);
          a7 = a6 + $urandom_range(1, 3);
          write_codes(8'(a0), 8'(a1), 8'(a2), 8'(a3), 8'(a4), 8'(a5), 8'(a6), 8'(a7));
        end
        2: begin
          write_codes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
          send_byte(8'h90, 1'b1, 1'b0);
        end
        3, 7: begin
          write_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        4: begin
          write_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
          send_byte(8'h80, 1'b1, 1'b1);
        end
        5: write_codes(8'h80, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h93, 8'h9F, 8'hA0);
        6: write_codes(CFG_RESET[0], CFG_RESET[1], CFG_RESET[2], CFG_RESET[3],
                       CFG_RESET[4], CFG_RESET[5], CFG_RESET[6], CFG_RESET[7]);
        default: ;
      endcase
      if (ph == 3) calm = 1'b1;
      target = sent_count + ITEMS_PER_PHASE;
      while (sent_count < target) begin
        if ($urandom_range(9) == 0) send_noise();
        else send_track();
      end
      calm = 1'b0;
    end

    in_if.valid <= 1'b0;
    @(negedge clk);
    while (open_results != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && open_results == 0) begin
      $display("PASS music_track_event_parser_core");
    end else begin
      $display("FAIL music_track_event_parser_core");
    end
    $finish;
  end

endmodule
